// ===== rtl/tln_pkg.sv =====
package tln_pkg;

   // Field and register widths
   localparam int IDX_W       = 16;
   localparam int LEN_W       = 9;
   localparam int TOTAL_W     = 2 * LEN_W;
   localparam int CSR_INDEX_W = 4;

   // Long division: quotient bits resolved per pipeline stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = IDX_W / DIV_STEPS;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 4'd1;

   // Register reset values
   localparam logic [LEN_W-1:0] COLS_RESET = 9'd5;
   localparam logic [LEN_W-1:0] ROWS_RESET = 9'd6;

   // Division word: dividend bits shift out of work, quotient bits shift in
   typedef struct packed {
      logic [IDX_W-1:0] work;
      logic [LEN_W-1:0] rem;
      logic             in_range;
   } div_type;

   // Row and column selections of the six neighbors
   typedef struct packed {
      logic [LEN_W-1:0] row;
      logic [LEN_W-1:0] ru;
      logic [LEN_W-1:0] rd;
      logic [LEN_W-1:0] ce;
      logic [LEN_W-1:0] cw;
      logic [LEN_W-1:0] cr;
      logic [LEN_W-1:0] cl;
      logic             in_range;
   } nbr_type;

   // Row base offsets plus the column selections
   typedef struct packed {
      logic [TOTAL_W-1:0] base_row;
      logic [TOTAL_W-1:0] base_up;
      logic [TOTAL_W-1:0] base_dn;
      logic [LEN_W-1:0]   ce;
      logic [LEN_W-1:0]   cw;
      logic [LEN_W-1:0]   cr;
      logic [LEN_W-1:0]   cl;
      logic               in_range;
   } prod_type;

   // Zero acts as one, anything above the limit acts as the limit
   function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v, int maxv);
      logic [LEN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (int'(v) > maxv) begin
         r = LEN_W'(maxv);
      end
      return r;
   endfunction

endpackage

// ===== rtl/tln_div_stage.sv =====
module tln_div_stage #(
   parameter int STEPS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   input  logic                       load,
   input  tln_pkg::div_type           up_data,
   input  logic [tln_pkg::LEN_W-1:0]  divisor,
   output logic                       valid_ff,
   output tln_pkg::div_type           data_ff
);
   import tln_pkg::*;

   div_type data_in;

   // Restoring division, one quotient bit per step
   always_comb begin
      div_type        d;
      logic [LEN_W:0] t;
      logic           q;
      d = up_data;
      for (int i = 0; i < STEPS; i++) begin
         t = {d.rem, d.work[IDX_W-1]};
         q = 1'b0;
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
            q = 1'b1;
         end
         d.rem  = t[LEN_W-1:0];
         d.work = {d.work[IDX_W-2:0], q};
      end
      data_in = d;
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/triangular_lattice_neighbors.sv =====
// Neighbor index unit for a triangular lattice stored row by row, odd rows
// shifted half a cell. Each site index word gives one result word with the
// six wrapped neighbor indices (east, up-right, up-left, west, down-left,
// down-right) and an in_range flag; an index at or above cols*rows returns
// in_range low and all neighbors zero. The pipeline is eight stages deep:
// an input register, four long-division stages (four quotient bits each)
// splitting the index into row and column, a neighbor-select stage, a
// multiply stage forming row base offsets and the output register. It takes
// one word per cycle while the output is not stalled; per-stage valid bits
// let bubbles close up under output back-pressure. cols and rows (register
// index 0 and 1) must only be written while the pipeline is empty.
module triangular_lattice_neighbors #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tln_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tln_pkg::LEN_W-1:0]        csr_data,
   // request
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tln_pkg::IDX_W-1:0]        req_site_index,
   // response
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tln_pkg::IDX_W-1:0]        rsp_east,
   output logic [tln_pkg::IDX_W-1:0]        rsp_up_right,
   output logic [tln_pkg::IDX_W-1:0]        rsp_up_left,
   output logic [tln_pkg::IDX_W-1:0]        rsp_west,
   output logic [tln_pkg::IDX_W-1:0]        rsp_down_left,
   output logic [tln_pkg::IDX_W-1:0]        rsp_down_right,
   output logic                             rsp_in_range
);
   import tln_pkg::*;

   // Configuration, stored already clamped
   logic [LEN_W-1:0]   cols_ff;
   logic [LEN_W-1:0]   rows_ff;
   logic [TOTAL_W-1:0] total_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= clamp_len(COLS_RESET, MAX_COLS);
         rows_ff <= clamp_len(ROWS_RESET, MAX_ROWS);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS: cols_ff <= clamp_len(csr_data, MAX_COLS);
            CSR_ROWS: rows_ff <= clamp_len(csr_data, MAX_ROWS);
            default: ;
         endcase
      end
   end

   // Site count, refreshed every cycle
   always_ff @(posedge clock) begin
      total_ff <= cols_ff * rows_ff;
   end

   // Pipeline valid bits and ready chain
   logic                  in_v_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [DIV_STAGES:0]   div_v;
   div_type               div_d [0:DIV_STAGES];
   logic [DIV_STAGES:1]   div_rdy;
   logic                  nbr_v_ff;
   nbr_type               nbr_ff;
   nbr_type               nbr_in;
   logic                  prod_v_ff;
   prod_type              prod_ff;
   logic                  out_v_ff;
   logic                  in_rdy;
   logic                  nbr_rdy;
   logic                  prod_rdy;
   logic                  out_rdy;
   logic [IDX_W-1:0]      east_ff;
   logic [IDX_W-1:0]      up_right_ff;
   logic [IDX_W-1:0]      up_left_ff;
   logic [IDX_W-1:0]      west_ff;
   logic [IDX_W-1:0]      down_left_ff;
   logic [IDX_W-1:0]      down_right_ff;
   logic                  in_range_ff;

   // A stage loads when it is empty or its word moves on
   always_comb begin
      out_rdy  = !out_v_ff  || rsp_ready;
      prod_rdy = !prod_v_ff || out_rdy;
      nbr_rdy  = !nbr_v_ff  || prod_rdy;
      div_rdy[DIV_STAGES] = !div_v[DIV_STAGES] || nbr_rdy;
      for (int k = DIV_STAGES - 1; k >= 1; k--) begin
         div_rdy[k] = !div_v[k] || div_rdy[k+1];
      end
      in_rdy = !in_v_ff || div_rdy[1];
   end

   assign req_ready = in_rdy;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (in_rdy) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && req_valid) begin
         idx_ff <= req_site_index;
      end
   end

   // Feed of the divider, range check alongside
   assign div_v[0]          = in_v_ff;
   assign div_d[0].work     = idx_ff;
   assign div_d[0].rem      = '0;
   assign div_d[0].in_range = TOTAL_W'(idx_ff) < total_ff;

   // Division stages: index / cols gives row and column
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      tln_div_stage #(
         .STEPS (DIV_STEPS)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_v[k-1]),
         .load     (div_rdy[k]),
         .up_data  (div_d[k-1]),
         .divisor  (cols_ff),
         .valid_ff (div_v[k]),
         .data_ff  (div_d[k])
      );
   end

   // Neighbor columns and rows with wrap
   always_comb begin
      logic [LEN_W-1:0] row;
      logic [LEN_W-1:0] col;
      logic [LEN_W:0]   row_p1;
      logic [LEN_W:0]   col_p1;
      row    = div_d[DIV_STAGES].work[LEN_W-1:0];
      col    = div_d[DIV_STAGES].rem;
      row_p1 = {1'b0, row} + (LEN_W+1)'(1);
      col_p1 = {1'b0, col} + (LEN_W+1)'(1);
      nbr_in.row      = row;
      nbr_in.ce       = (col_p1 == {1'b0, cols_ff}) ? '0 : col_p1[LEN_W-1:0];
      nbr_in.cw       = (col == '0) ? cols_ff - LEN_W'(1) : col - LEN_W'(1);
      nbr_in.ru       = (row_p1 == {1'b0, rows_ff}) ? '0 : row_p1[LEN_W-1:0];
      nbr_in.rd       = (row == '0) ? rows_ff - LEN_W'(1) : row - LEN_W'(1);
      nbr_in.cr       = row[0] ? nbr_in.ce : col;
      nbr_in.cl       = row[0] ? col : nbr_in.cw;
      nbr_in.in_range = div_d[DIV_STAGES].in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nbr_v_ff <= 1'b0;
      end else if (nbr_rdy) begin
         nbr_v_ff <= div_v[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (nbr_rdy && div_v[DIV_STAGES]) begin
         nbr_ff <= nbr_in;
      end
   end

   // Row base offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else if (prod_rdy) begin
         prod_v_ff <= nbr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_rdy && nbr_v_ff) begin
         prod_ff.base_row <= nbr_ff.row * cols_ff;
         prod_ff.base_up  <= nbr_ff.ru * cols_ff;
         prod_ff.base_dn  <= nbr_ff.rd * cols_ff;
         prod_ff.ce       <= nbr_ff.ce;
         prod_ff.cw       <= nbr_ff.cw;
         prod_ff.cr       <= nbr_ff.cr;
         prod_ff.cl       <= nbr_ff.cl;
         prod_ff.in_range <= nbr_ff.in_range;
      end
   end

   // Output register: base plus column, zero when out of range
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= prod_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && prod_v_ff) begin
         if (prod_ff.in_range) begin
            east_ff       <= IDX_W'(prod_ff.base_row + TOTAL_W'(prod_ff.ce));
            up_right_ff   <= IDX_W'(prod_ff.base_up  + TOTAL_W'(prod_ff.cr));
            up_left_ff    <= IDX_W'(prod_ff.base_up  + TOTAL_W'(prod_ff.cl));
            west_ff       <= IDX_W'(prod_ff.base_row + TOTAL_W'(prod_ff.cw));
            down_left_ff  <= IDX_W'(prod_ff.base_dn  + TOTAL_W'(prod_ff.cl));
            down_right_ff <= IDX_W'(prod_ff.base_dn  + TOTAL_W'(prod_ff.cr));
         end else begin
            east_ff       <= '0;
            up_right_ff   <= '0;
            up_left_ff    <= '0;
            west_ff       <= '0;
            down_left_ff  <= '0;
            down_right_ff <= '0;
         end
         in_range_ff <= prod_ff.in_range;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_east       = east_ff;
   assign rsp_up_right   = up_right_ff;
   assign rsp_up_left    = up_left_ff;
   assign rsp_west       = west_ff;
   assign rsp_down_left  = down_left_ff;
   assign rsp_down_right = down_right_ff;
   assign rsp_in_range   = in_range_ff;

endmodule

// ===== rtl/tln_checker.sv =====
module tln_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [tln_pkg::IDX_W-1:0]        req_site_index,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tln_pkg::IDX_W-1:0]        rsp_east,
   input logic [tln_pkg::IDX_W-1:0]        rsp_up_right,
   input logic [tln_pkg::IDX_W-1:0]        rsp_up_left,
   input logic [tln_pkg::IDX_W-1:0]        rsp_west,
   input logic [tln_pkg::IDX_W-1:0]        rsp_down_left,
   input logic [tln_pkg::IDX_W-1:0]        rsp_down_right,
   input logic                             rsp_in_range
);

   // A stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_site_index))
      else $error("request word changed while stalled");

   // A stalled response word holds its east, west and in_range fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_east) && $stable(rsp_west)
         && $stable(rsp_in_range))
      else $error("response word changed while stalled");

   // Out-of-range word carries no neighbors
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_east == '0 && rsp_up_right == '0
         && rsp_up_left == '0 && rsp_west == '0 && rsp_down_left == '0
         && rsp_down_right == '0)
      else $error("out-of-range word with nonzero neighbor");

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Register writes are never stalled
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind triangular_lattice_neighbors tln_checker u_tln_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
   import tln_pkg::*;

   localparam int MAX_COLS       = 256;
   localparam int MAX_ROWS       = 256;
   localparam int PIPE_LATENCY   = 8;
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int WORDS_PER_SET  = 140;
   localparam int RANDOM_SETS    = 3;
   localparam int MAX_REPORTS    = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_ROWS + CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   // one result word, fields in port order
   typedef struct packed {
      logic [IDX_W-1:0] east;
      logic [IDX_W-1:0] up_right;
      logic [IDX_W-1:0] up_left;
      logic [IDX_W-1:0] west;
      logic [IDX_W-1:0] down_left;
      logic [IDX_W-1:0] down_right;
      logic             in_range;
   } nbr_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]       csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [IDX_W-1:0]       req_site_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   nbr_word_type           rsp_word;

   // lattice shape as last written
   logic [LEN_W-1:0] lattice_cols = COLS_RESET;
   logic [LEN_W-1:0] lattice_rows = ROWS_RESET;

   logic [IDX_W-1:0] site_queue[$];
   nbr_word_type     neighbor_queue[$];
   int               idle_pct = 0;
   int               req_gap = 0;
   int               rsp_stall = 0;
   int               quiet_cycles = 0;
   int               errors = 0;

   always #5 clock = ~clock;

   triangular_lattice_neighbors #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_site_index(req_site_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_east      (rsp_word.east),
      .rsp_up_right  (rsp_word.up_right),
      .rsp_up_left   (rsp_word.up_left),
      .rsp_west      (rsp_word.west),
      .rsp_down_left (rsp_word.down_left),
      .rsp_down_right(rsp_word.down_right),
      .rsp_in_range  (rsp_word.in_range)
   );

   // zero counts as one, oversize counts as the limit
   function automatic int usable_len(logic [LEN_W-1:0] v, int limit);
      if (v == 0) begin
         return 1;
      end
      return (int'(v) > limit) ? limit : int'(v);
   endfunction

   // six wrapped neighbors of a site under the current shape
   function automatic nbr_word_type lattice_neighbors(logic [IDX_W-1:0] site);
      int c, r, row, col, ce, cw, cr, cl, ru, rd;
      nbr_word_type w;
      c = usable_len(lattice_cols, MAX_COLS);
      r = usable_len(lattice_rows, MAX_ROWS);
      w = '0;
      if (int'(site) < c * r) begin
         row = int'(site) / c;
         col = int'(site) % c;
         ce = (col + 1 == c) ? 0 : col + 1;
         cw = (col == 0) ? c - 1 : col - 1;
         // odd rows sit half a cell right
         cr = row[0] ? ce : col;
         cl = row[0] ? col : cw;
         ru = (row + 1 == r) ? 0 : row + 1;
         rd = (row == 0) ? r - 1 : row - 1;
         w.east       = IDX_W'(row * c + ce);
         w.up_right   = IDX_W'(ru * c + cr);
         w.up_left    = IDX_W'(ru * c + cl);
         w.west       = IDX_W'(row * c + cw);
         w.down_left  = IDX_W'(rd * c + cl);
         w.down_right = IDX_W'(rd * c + cr);
         w.in_range   = 1'b1;
      end
      return w;
   endfunction

   // random site: mostly in range, some row edges, some past the end, some anything
   function automatic logic [IDX_W-1:0] pick_site();
      int c, total, pick, row;
      c = usable_len(lattice_cols, MAX_COLS);
      total = c * usable_len(lattice_rows, MAX_ROWS);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         return IDX_W'($urandom_range(0, total - 1));
      end else if (pick < 15) begin
         row = $urandom_range(0, total / c - 1);
         return IDX_W'(row * c + ($urandom_range(0, 1) ? c - 1 : 0));
      end else if (pick < 17 && total < 65536) begin
         return IDX_W'(total + $urandom_range(0, 3));
      end
      return IDX_W'($urandom_range(0, 65535));
   endfunction

   // register write; caller starts at a rising edge and lowers valid afterwards
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [LEN_W-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_COLS) begin
         lattice_cols = data;
      end else if (index == CSR_ROWS) begin
         lattice_rows = data;
      end
   endtask

   // wait for the pipeline to empty, then let it settle
   task automatic drain();
      do @(negedge clock);
      while (site_queue.size() != 0 || req_valid || neighbor_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: predicts on acceptance, idles in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            neighbor_queue.push_back(lattice_neighbors(req_site_index));
         end
         if (!req_valid || req_ready) begin
            if (req_gap == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
               req_gap = $urandom_range(1, 8);
            end
            if (req_gap != 0 || site_queue.size() == 0) begin
               if (req_gap != 0) begin
                  req_gap--;
               end
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_site_index <= site_queue.pop_front();
            end
         end
      end
   end

   // response monitor: checks each word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (neighbor_queue.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected response word: %p", rsp_word);
            end
         end else if (rsp_word !== neighbor_queue[0]) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("mismatch: exp E=%0d UR=%0d UL=%0d W=%0d DL=%0d DR=%0d in=%0b",
                        neighbor_queue[0].east, neighbor_queue[0].up_right,
                        neighbor_queue[0].up_left, neighbor_queue[0].west,
                        neighbor_queue[0].down_left, neighbor_queue[0].down_right,
                        neighbor_queue[0].in_range);
               $display("          got E=%0d UR=%0d UL=%0d W=%0d DL=%0d DR=%0d in=%0b",
                        rsp_word.east, rsp_word.up_right, rsp_word.up_left,
                        rsp_word.west, rsp_word.down_left, rsp_word.down_right,
                        rsp_word.in_range);
            end
            void'(neighbor_queue.pop_front());
         end else begin
            void'(neighbor_queue.pop_front());
         end
      end
      // back-pressure bursts
      if (rsp_stall == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         rsp_stall = $urandom_range(1, 8);
      end
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // phase sequencer: shape settings, then words for each shape
   initial begin
      int set_cols[] = '{1, 256, 0, 511, 7, 3, 1, 256, 12};
      int set_rows[] = '{1, 256, 0, 300, 5, 2, 8, 1, 10};
      int n_sets, cols_val, rows_val;
      n_sets = set_cols.size() + RANDOM_SETS;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset shape 5x6: corners, row seams, just past the end, bit patterns
      @(negedge clock);
      idle_pct = 20;
      site_queue = '{16'd0, 16'd4, 16'd5, 16'd9, 16'd12, 16'd17, 16'd24, 16'd25,
                     16'd29, 16'd30, 16'd31, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000};
      repeat (WORDS_PER_SET) site_queue.push_back(pick_site());
      drain();

      for (int s = 0; s < n_sets; s++) begin
         if (s < set_cols.size()) begin
            cols_val = set_cols[s];
            rows_val = set_rows[s];
         end else begin
            cols_val = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 511);
            rows_val = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 511);
         end
         write_reg(CSR_COLS, LEN_W'(cols_val));
         // writes to unmapped indexes must leave the shape alone
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      LEN_W'($urandom_range(0, 511)));
         end
         write_reg(CSR_ROWS, LEN_W'(rows_val));
         csr_valid <= 1'b0;
         @(negedge clock);
         // last set runs at full rate
         idle_pct = (s == n_sets - 1) ? 0 : $urandom_range(0, 3) * 10;
         repeat (WORDS_PER_SET) site_queue.push_back(pick_site());
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tln_pkg.sv
rtl/tln_div_stage.sv
rtl/triangular_lattice_neighbors.sv
rtl/tln_checker.sv
bench/testbench.sv
